// ===== design/cslc_pkg.sv =====
package cslc_pkg;

  localparam int unsigned CLASS_W = 4;

  typedef enum logic [3:0] {
    M_NORMAL   = 4'd0,
    M_SLASH    = 4'd1,
    M_LINECOM  = 4'd2,
    M_PREPROC  = 4'd3,
    M_STRING   = 4'd4,
    M_CHAR     = 4'd5,
    M_WORD     = 4'd6,
    M_LONGWORD = 4'd7,
    M_NUMBER   = 4'd8
  } lex_mode_t;

  typedef enum logic [3:0] {
    C_DEFAULT  = 4'd0,
    C_KEYWORD  = 4'd1,
    C_TYPE     = 4'd2,
    C_STRING   = 4'd3,
    C_CHAR     = 4'd4,
    C_COMMENT  = 4'd5,
    C_PREPROC  = 4'd6,
    C_NUMBER   = 4'd7,
    C_OPERATOR = 4'd8
  } tok_class_t;

  localparam int unsigned ROM_N   = 59;
  localparam int unsigned ROM_KW  = 32;
  localparam int unsigned ROM_CHR = 16;
  localparam int unsigned ROM_IW  = 6;

  typedef logic [ROM_CHR*8-1:0] rom_word_t;

  // Words are left-aligned: byte k sits at bits [8*(ROM_CHR-k)-1 -: 8].
  function automatic rom_word_t rom_word(input logic [ROM_IW-1:0] idx);
    rom_word_t w;
    w = '0;
    case (idx)
      6'd0:  w = {"auto", 96'h0};
      6'd1:  w = {"break", 88'h0};
      6'd2:  w = {"case", 96'h0};
      6'd3:  w = {"const", 88'h0};
      6'd4:  w = {"continue", 64'h0};
      6'd5:  w = {"default", 72'h0};
      6'd6:  w = {"do", 112'h0};
      6'd7:  w = {"else", 96'h0};
      6'd8:  w = {"enum", 96'h0};
      6'd9:  w = {"extern", 80'h0};
      6'd10: w = {"for", 104'h0};
      6'd11: w = {"goto", 96'h0};
      6'd12: w = {"if", 112'h0};
      6'd13: w = {"inline", 80'h0};
      6'd14: w = {"register", 64'h0};
      6'd15: w = {"return", 80'h0};
      6'd16: w = {"signed", 80'h0};
      6'd17: w = {"sizeof", 80'h0};
      6'd18: w = {"static", 80'h0};
      6'd19: w = {"struct", 80'h0};
      6'd20: w = {"switch", 80'h0};
      6'd21: w = {"typedef", 72'h0};
      6'd22: w = {"union", 88'h0};
      6'd23: w = {"volatile", 64'h0};
      6'd24: w = {"while", 88'h0};
      6'd25: w = {"_Alignas", 64'h0};
      6'd26: w = {"_Alignof", 64'h0};
      6'd27: w = {"_Atomic", 72'h0};
      6'd28: w = {"_Generic", 64'h0};
      6'd29: w = {"_Noreturn", 56'h0};
      6'd30: w = {"_Static", "_assert", 16'h0};
      6'd31: w = {"_Thread", "_local", 24'h0};
      6'd32: w = {"char", 96'h0};
      6'd33: w = {"double", 80'h0};
      6'd34: w = {"float", 88'h0};
      6'd35: w = {"int", 104'h0};
      6'd36: w = {"long", 96'h0};
      6'd37: w = {"short", 88'h0};
      6'd38: w = {"unsigned", 64'h0};
      6'd39: w = {"void", 96'h0};
      6'd40: w = {"size_t", 80'h0};
      6'd41: w = {"ssize_t", 72'h0};
      6'd42: w = {"uint8_t", 72'h0};
      6'd43: w = {"uint", "16_t", 64'h0};
      6'd44: w = {"uint", "32_t", 64'h0};
      6'd45: w = {"uint", "64_t", 64'h0};
      6'd46: w = {"int8_t", 80'h0};
      6'd47: w = {"int16_t", 72'h0};
      6'd48: w = {"int32_t", 72'h0};
      6'd49: w = {"int64_t", 72'h0};
      6'd50: w = {"bool", 96'h0};
      6'd51: w = {"int", "ptr_t", 64'h0};
      6'd52: w = {"uint", "ptr_t", 56'h0};
      6'd53: w = {"off_t", 88'h0};
      6'd54: w = {"pid_t", 88'h0};
      6'd55: w = {"uid_t", 88'h0};
      6'd56: w = {"gid_t", 88'h0};
      6'd57: w = {"FILE", 96'h0};
      6'd58: w = {"va_list", 72'h0};
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic is_alpha_u(input logic [7:0] c);
    return (c inside {["a":"z"], ["A":"Z"], "_"});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {["0":"9"]});
  endfunction

  function automatic logic is_numbyte(input logic [7:0] c);
    return (c inside {["0":"9"], ".", "x", "X", ["a":"f"], ["A":"F"], "u", "U", "l", "L"});
  endfunction

  function automatic logic is_opbyte(input logic [7:0] c);
    return (c inside {"+", "-", "*", "/", "%", "=", "<", ">", "!", "&", "|", "^", "~",
                      "?", ":"});
  endfunction

endpackage

// ===== design/cslc_if.sv =====
interface cslc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;
  modport source (output valid, output ch, output line_end, input ready);
  modport sink (input valid, input ch, input line_end, output ready);
endinterface

interface cslc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_class;
  logic       line_last;
  logic       run_last;
  modport source (output valid, output token_class, output line_last, output run_last,
                  input ready);
  modport sink (input valid, input token_class, input line_last, input run_last,
                output ready);
endinterface

// ===== design/cslc_ram.sv =====
module cslc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/c_source_lexer_classifier.sv =====
// C source byte classifier. Bytes come in one per word with a line-end flag;
// one class word per byte goes out, in order, for the first LINE_MAX bytes of
// a line (later bytes are dropped). A plain byte is accepted, classified, sends
// its class words and is closed. An identifier of up to WORD_MAX bytes is stored
// in a RAM as it arrives; at its end a sequencer walks the 59-entry keyword/type
// ROM, comparing one character per RAM read and compare step, then sends one
// word per stored character plus any word the ending byte produces. Input is
// held off from accept until the byte's last word is taken.
// No clearing pass after reset.
module c_source_lexer_classifier #(
  parameter int unsigned LINE_MAX = 256,
  parameter int unsigned WORD_MAX = 32
) (
  input logic clk,
  input logic rst_n,
  cslc_in_if.sink    in_ch,
  cslc_out_if.source out_ch
);
  import cslc_pkg::*;

  localparam int unsigned PW = $clog2(LINE_MAX + 1);
  localparam int unsigned AW = $clog2(WORD_MAX);
  localparam int unsigned LW = $clog2(WORD_MAX + 1);
  localparam int unsigned CW = $clog2(ROM_CHR + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PROC  = 7'b0000010,
    S_EMIT  = 7'b0000100,
    S_MRD   = 7'b0001000,
    S_MCMP  = 7'b0010000,
    S_FLUSH = 7'b0100000,
    S_LONG  = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  lex_mode_t  mode_r, mode_nxt;
  logic       blk_r, blk_nxt, star_r, star_nxt, esc_r, esc_nxt, pnl_r, pnl_nxt;
  logic [LW-1:0] wlen_r, wlen_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0] c_r, c_nxt;
  logic       end_r, end_nxt, last_r, last_nxt, start_r, start_nxt;
  // pending output words (up to two queued single emits)
  logic [1:0] qn_r, qn_nxt;
  tok_class_t q0c_r, q0c_nxt, q1c_r, q1c_nxt;
  logic       q0l_r, q0l_nxt, q1l_r, q1l_nxt;
  logic       disp_r, disp_nxt;     // dispatch c_r in normal mode, after any flush
  logic       fend_r, fend_nxt;     // line_last on final flushed byte
  logic [ROM_IW-1:0] ri_r, ri_nxt;
  logic [LW-1:0] k_r, k_nxt;
  tok_class_t fcls_r, fcls_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  cslc_ram #(.WIDTH(8), .DEPTH(WORD_MAX)) u_word (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  rom_word_t rw;
  logic [7:0] rch;
  assign rw  = rom_word(ri_r);
  assign rch = (k_r < LW'(ROM_CHR)) ? rw[8*ROM_CHR-1 - 8*k_r[CW-1:0] -: 8] : 8'h00;

  // dispatch of the current byte into the pending queue
  lex_mode_t  d_mode;
  tok_class_t d_cls;
  logic       d_emit, d_word;
  always_comb begin
    d_mode = M_NORMAL; d_cls = C_DEFAULT; d_emit = 1'b1; d_word = 1'b0;
    if (c_r == "/") begin
      if (last_r) d_cls = C_OPERATOR;
      else begin d_emit = 1'b0; d_mode = M_SLASH; end
    end else if (c_r == "#" && start_r) begin
      d_mode = M_PREPROC; d_cls = C_PREPROC;
    end else if (c_r == "\"") begin
      d_mode = M_STRING; d_cls = C_STRING;
    end else if (c_r == "'") begin
      d_mode = M_CHAR; d_cls = C_CHAR;
    end else if (is_alpha_u(c_r)) begin
      d_emit = 1'b0; d_word = 1'b1; d_mode = M_WORD;
    end else if (is_digit(c_r)) begin
      d_mode = M_NUMBER; d_cls = C_NUMBER;
    end else if (is_opbyte(c_r)) begin
      d_cls = C_OPERATOR;
    end
  end

  logic wbyte;
  assign wbyte = is_alpha_u(c_r) || is_digit(c_r);

  // a word ended by the line still has to be flushed after the queued words
  logic flush_wait;
  assign flush_wait = fend_r && (mode_r == M_WORD) && (wlen_r != '0);

  always_comb begin
    state_nxt = state_r; mode_nxt = mode_r; blk_nxt = blk_r; star_nxt = star_r;
    esc_nxt = esc_r; pnl_nxt = pnl_r; wlen_nxt = wlen_r; pos_nxt = pos_r;
    c_nxt = c_r; end_nxt = end_r; last_nxt = last_r; start_nxt = start_r;
    qn_nxt = qn_r; q0c_nxt = q0c_r; q1c_nxt = q1c_r; q0l_nxt = q0l_r; q1l_nxt = q1l_r;
    disp_nxt = disp_r; fend_nxt = fend_r; ri_nxt = ri_r; k_nxt = k_r;
    fcls_nxt = fcls_r;
    we = 1'b0; waddr = wlen_r[AW-1:0]; wdata = c_r; raddr = k_r[AW-1:0];
    in_ch.ready = (state_r == S_IDLE);
    out_ch.valid = 1'b0; out_ch.token_class = C_DEFAULT; out_ch.line_last = 1'b0;
    out_ch.run_last = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          c_nxt = in_ch.ch; end_nxt = in_ch.line_end;
          if (pos_r >= PW'(LINE_MAX)) begin
            if (in_ch.line_end) pos_nxt = '0;
          end else begin
            last_nxt = in_ch.line_end || (pos_r == PW'(LINE_MAX - 1));
            start_nxt = (pos_r == '0) || pnl_r;
            state_nxt = S_PROC;
          end
        end
      end
      S_PROC: begin
        // classify one byte; queue results, maybe start a word flush or long-word output
        qn_nxt = 2'd0; disp_nxt = 1'b0; fend_nxt = 1'b0;
        state_nxt = S_EMIT;
        if (blk_r) begin
          qn_nxt = 2'd1; q0c_nxt = C_COMMENT; q0l_nxt = last_r;
          if (star_r && c_r == "/") begin blk_nxt = 1'b0; star_nxt = 1'b0; end
          else star_nxt = (c_r == "*");
        end else begin
          case (mode_r)
            M_SLASH: begin
              if (c_r == "/" || c_r == "*") begin
                qn_nxt = 2'd2; q0c_nxt = C_COMMENT; q0l_nxt = 1'b0;
                q1c_nxt = C_COMMENT; q1l_nxt = last_r;
                if (c_r == "/") mode_nxt = M_LINECOM;
                else begin blk_nxt = 1'b1; star_nxt = 1'b0; mode_nxt = M_NORMAL; end
              end else begin
                q0c_nxt = C_OPERATOR; q0l_nxt = 1'b0; q1c_nxt = d_cls; q1l_nxt = last_r;
                qn_nxt = d_emit ? 2'd2 : 2'd1; mode_nxt = d_mode;
                if (d_word) begin we = 1'b1; waddr = '0; wlen_nxt = LW'(1); end
                if (d_word && last_r) begin
                  fend_nxt = 1'b1; ri_nxt = '0; k_nxt = '0; fcls_nxt = C_DEFAULT;
                end
              end
            end
            M_LINECOM: begin qn_nxt = 2'd1; q0c_nxt = C_COMMENT; q0l_nxt = last_r; end
            M_PREPROC: begin qn_nxt = 2'd1; q0c_nxt = C_PREPROC; q0l_nxt = last_r; end
            M_STRING, M_CHAR: begin
              qn_nxt = 2'd1; q0l_nxt = last_r;
              q0c_nxt = (mode_r == M_STRING) ? C_STRING : C_CHAR;
              if (esc_r) esc_nxt = 1'b0;
              else if (c_r == "\\") esc_nxt = 1'b1;
              else if ((mode_r == M_STRING && c_r == "\"") ||
                       (mode_r == M_CHAR && c_r == "'")) mode_nxt = M_NORMAL;
            end
            M_WORD: begin
              if (wbyte) begin
                if (wlen_r < LW'(WORD_MAX)) begin
                  we = 1'b1; wlen_nxt = wlen_r + 1'b1;
                  if (last_r) begin
                    fend_nxt = 1'b1; ri_nxt = '0; k_nxt = '0; fcls_nxt = C_DEFAULT;
                    state_nxt = S_MRD;
                  end
                end else begin
                  k_nxt = '0; mode_nxt = M_LONGWORD;
                  state_nxt = S_LONG;
                end
              end else begin
                disp_nxt = 1'b1; ri_nxt = '0; k_nxt = '0; fcls_nxt = C_DEFAULT;
                state_nxt = S_MRD;
              end
            end
            M_LONGWORD, M_NUMBER: begin
              if ((mode_r == M_LONGWORD && wbyte) ||
                  (mode_r == M_NUMBER && is_numbyte(c_r))) begin
                qn_nxt = 2'd1; q0l_nxt = last_r;
                q0c_nxt = (mode_r == M_NUMBER) ? C_NUMBER : C_DEFAULT;
              end else begin
                disp_nxt = 1'b1; wlen_nxt = '0; state_nxt = S_EMIT;
              end
            end
            default: begin disp_nxt = 1'b1; wlen_nxt = '0; end
          endcase
        end
        // a word begun by dispatch at line end flushes after the operator
        if (fend_nxt && mode_r == M_SLASH) begin
          qn_nxt = 2'd1; state_nxt = S_EMIT; disp_nxt = 1'b0;
        end
      end
      S_MRD: begin
        state_nxt = S_MCMP;
      end
      S_MCMP: begin
        // one char of stored word vs ROM entry ri_r per read/compare pair
        if (k_r == wlen_r) begin
          if (rch == 8'h00) begin
            fcls_nxt = (ri_r < ROM_IW'(ROM_KW)) ? C_KEYWORD : C_TYPE;
            k_nxt = '0; state_nxt = S_FLUSH;
          end else begin
            k_nxt = '0; state_nxt = S_MRD;
            if (ri_r == ROM_IW'(ROM_N - 1)) begin fcls_nxt = C_DEFAULT; state_nxt = S_FLUSH; end
            else ri_nxt = ri_r + 1'b1;
          end
        end else if (rdata == rch && rch != 8'h00) begin
          k_nxt = k_r + 1'b1; state_nxt = S_MRD;
        end else begin
          k_nxt = '0; state_nxt = S_MRD;
          if (ri_r == ROM_IW'(ROM_N - 1)) begin fcls_nxt = C_DEFAULT; state_nxt = S_FLUSH; end
          else ri_nxt = ri_r + 1'b1;
        end
      end
      S_FLUSH: begin
        out_ch.valid = 1'b1; out_ch.token_class = fcls_r;
        out_ch.line_last = (k_r + 1'b1 == wlen_r) && fend_r;
        // the ending byte may itself add a word after the flush
        out_ch.run_last = (k_r + 1'b1 == wlen_r) && !(disp_r && d_emit);
        if (out_ch.ready) begin
          k_nxt = k_r + 1'b1;
          if (k_r + 1'b1 == wlen_r) begin
            wlen_nxt = '0; mode_nxt = M_NORMAL; qn_nxt = 2'd0;
            state_nxt = disp_r ? S_PROC : S_EMIT;
            if (disp_r) mode_nxt = M_NORMAL;
            // re-enter PROC in NORMAL mode to dispatch the ending byte
          end
        end
      end
      S_LONG: begin
        out_ch.valid = 1'b1; out_ch.token_class = C_DEFAULT;
        out_ch.line_last = (k_r == wlen_r) && last_r;
        out_ch.run_last = (k_r == wlen_r);
        if (out_ch.ready) begin
          k_nxt = k_r + 1'b1;
          if (k_r == wlen_r) begin wlen_nxt = '0; qn_nxt = 2'd0; state_nxt = S_EMIT; end
        end
      end
      S_EMIT: begin
        if (disp_r) begin
          // dispatch from normal mode
          disp_nxt = 1'b0; mode_nxt = d_mode;
          qn_nxt = d_emit ? 2'd1 : 2'd0; q0c_nxt = d_cls; q0l_nxt = last_r;
          if (d_word) begin
            we = 1'b1; waddr = '0; wlen_nxt = LW'(1);
            if (last_r) begin
              fend_nxt = 1'b1; ri_nxt = '0; k_nxt = '0; fcls_nxt = C_DEFAULT;
              state_nxt = S_MRD;
            end
          end
        end else if (qn_r != 2'd0) begin
          out_ch.valid = 1'b1; out_ch.token_class = q0c_r; out_ch.line_last = q0l_r;
          out_ch.run_last = (qn_r == 2'd1) && !flush_wait;
          if (out_ch.ready) begin
            qn_nxt = qn_r - 1'b1; q0c_nxt = q1c_r; q0l_nxt = q1l_r;
          end
        end else if (flush_wait) begin
          ri_nxt = '0; k_nxt = '0; fcls_nxt = C_DEFAULT; state_nxt = S_MRD;
        end else begin
          // byte done: end-of-step bookkeeping
          state_nxt = S_IDLE;
          pnl_nxt = (c_r == 8'h0A || c_r == 8'h0D);
          pos_nxt = pos_r + 1'b1;
          if (last_r) begin
            mode_nxt = M_NORMAL; star_nxt = 1'b0; esc_nxt = 1'b0; wlen_nxt = '0;
            pnl_nxt = 1'b0; pos_nxt = end_r ? '0 : PW'(LINE_MAX);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; mode_r <= M_NORMAL; blk_r <= 1'b0; star_r <= 1'b0;
      esc_r <= 1'b0; pnl_r <= 1'b0; wlen_r <= '0; pos_r <= '0; qn_r <= 2'd0;
      disp_r <= 1'b0; fend_r <= 1'b0;
    end else begin
      state_r <= state_nxt; mode_r <= mode_nxt; blk_r <= blk_nxt; star_r <= star_nxt;
      esc_r <= esc_nxt; pnl_r <= pnl_nxt; wlen_r <= wlen_nxt; pos_r <= pos_nxt;
      qn_r <= qn_nxt; disp_r <= disp_nxt; fend_r <= fend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt; end_r <= end_nxt; last_r <= last_nxt; start_r <= start_nxt;
    q0c_r <= q0c_nxt; q1c_r <= q1c_nxt; q0l_r <= q0l_nxt; q1l_r <= q1l_nxt;
    ri_r <= ri_nxt; k_r <= k_nxt; fcls_r <= fcls_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid) else $error("output while accepting");
  assert property (@(posedge clk) disable iff (!rst_n)
    wlen_r <= LW'(WORD_MAX)) else $error("word length overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH) |-> (wlen_r != '0)) else $error("flush of empty word");

endmodule
